FILE: rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/bti_pkg.sv
package bti_pkg;
	localparam int TableDepth = 64;
	localparam int IdxW = 6;
	localparam int CntW = 7;
	localparam int DayW = 20;
	localparam int TimeW = 17;
	localparam int ValW = 32;
	localparam int KeyW = DayW + TimeW;
	// divider width covers both the value span and remainder times day offset
	localparam int DivW = 2 * DayW;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] MODE_EXACT = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_STAIRS = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_BOUNDS = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic CFG_MODE = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_CHK0, S_RDLAST, S_CHKLAST, S_SCAN, S_RDLEFT, S_GOTLEFT,
		S_DIV1, S_MUL, S_DIV2, S_DONE
	} state_t;

	// divider request and response
	typedef struct packed {
		logic start;
		logic [DivW-1:0] dividend;
		logic [DayW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DivW-1:0] quot;
		logic [DayW-1:0] rem;
	} div_rsp_t;
endpackage

FILE: rtl/bti_divider.sv
// restoring divider, one quotient bit per cycle
module bti_divider (
	input logic clk,
	input logic arst_n,
	input bti_pkg::div_req_t req,
	output bti_pkg::div_rsp_t rsp
);
	localparam int QW = bti_pkg::DivW;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] quot_q;
	logic [bti_pkg::DayW-1:0] rem_q;
	logic [bti_pkg::DayW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [bti_pkg::DayW:0] trial;

	assign trial = {rem_q, quot_q[QW-1]} - {1'b0, dvs_q};

	// iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[bti_pkg::DayW]) begin
				rem_q <= trial[bti_pkg::DayW-1:0];
				quot_q <= {quot_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[bti_pkg::DayW-2:0], quot_q[QW-1]};
				quot_q <= {quot_q[QW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem = rem_q;
endmodule

FILE: rtl/bti_table_mem.sv
// breakpoint storage, one write and one registered read port
module bti_table_mem (
	input logic clk,
	input logic wr_en,
	input logic [bti_pkg::IdxW-1:0] wr_addr,
	input logic [bti_pkg::DayW-1:0] wr_day,
	input logic [bti_pkg::TimeW-1:0] wr_time,
	input logic [bti_pkg::ValW-1:0] wr_val,
	input logic [bti_pkg::IdxW-1:0] rd_addr,
	output logic [bti_pkg::DayW-1:0] rd_day,
	output logic [bti_pkg::TimeW-1:0] rd_time,
	output logic [bti_pkg::ValW-1:0] rd_val
);
	localparam int EW = bti_pkg::DayW + bti_pkg::TimeW + bti_pkg::ValW;
	logic [EW-1:0] mem [bti_pkg::TableDepth];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_day, wr_time, wr_val};
		end
		rd_q <= mem[rd_addr];
	end

	assign {rd_day, rd_time, rd_val} = rd_q;
endmodule

FILE: rtl/breakpoint_table_interpolator.sv
// Breakpoint table interpolator: a 64-entry table of (day, time, Q16.16 value) loaded
// by load words, queried in exact, linear or stairs mode. One word at a time. A load
// goes through the done state to the output register. A query reads the table through
// one memory port, one entry a cycle, and linear mode can add two passes of the shared
// bit-serial divider with a multiply step between them. The result sits in an output
// register and the next word is taken once it is delivered.
`include "assert_macros.svh"
module breakpoint_table_interpolator (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic operation,
	input logic [5:0] entry_index,
	input logic [19:0] key_day,
	input logic [16:0] key_time,
	input logic signed [31:0] entry_value,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] result_value,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [6:0] cfg_data
);
	localparam int IW = bti_pkg::IdxW;
	localparam int DW = bti_pkg::DayW;
	localparam int VW = bti_pkg::ValW;
	localparam int KW = bti_pkg::KeyW;
	localparam int QW = bti_pkg::DivW;

	bti_pkg::state_t state_q, state_d;
	logic [1:0] mode_q;
	logic [bti_pkg::CntW-1:0] count_q;
	logic [DW-1:0] kday_q;
	logic [KW-1:0] key_q;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] last_q;
	logic [VW-1:0] lo_q, hi_q;
	logic [DW-1:0] span_q, dt_q;
	logic neg_q;
	logic [VW:0] mag_q;
	logic [VW+DW:0] qmul_q;
	logic [VW+DW:0] prod_q;
	logic [VW-1:0] res_q;
	logic [1:0] st_q;
	logic ovld_q;

	logic [DW-1:0] rd_day;
	logic [bti_pkg::TimeW-1:0] rd_time;
	logic [VW-1:0] rd_val;
	logic [KW-1:0] rd_key;
	logic wr_en;
	logic [IW-1:0] rd_addr;

	bti_pkg::div_req_t dreq;
	bti_pkg::div_rsp_t drsp;

	logic accept;
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == bti_pkg::S_IDLE) && !ovld_q;
	assign cfg_ready = 1'b1;
	assign wr_en = accept && (operation == bti_pkg::OP_LOAD);
	assign rd_key = {rd_day, rd_time};

	bti_table_mem u_mem (
		.clk(clk), .wr_en(wr_en), .wr_addr(entry_index), .wr_day(key_day),
		.wr_time(key_time), .wr_val(entry_value), .rd_addr(rd_addr),
		.rd_day(rd_day), .rd_time(rd_time), .rd_val(rd_val)
	);

	bti_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bti_pkg::MODE_LINEAR;
			count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == bti_pkg::CFG_MODE) begin
				mode_q <= cfg_data[1:0];
			end else if (cfg_data > 7'(bti_pkg::TableDepth)) begin
				count_q <= 7'(bti_pkg::TableDepth);
			end else begin
				count_q <= cfg_data;
			end
		end
	end

	// next state and read address
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		rd_addr = idx_q;
		dreq.start = 1'b0;
		dreq.dividend = QW'(mag_q);
		dreq.divisor = span_q;
		case (state_q)
			bti_pkg::S_IDLE: begin
				rd_addr = '0;
				if (accept) begin
					if (operation == bti_pkg::OP_LOAD || count_q == '0 ||
							mode_q == bti_pkg::MODE_UNUSED) begin
						state_d = bti_pkg::S_DONE;
					end else if (mode_q == bti_pkg::MODE_EXACT) begin
						idx_d = '0;
						state_d = bti_pkg::S_SCAN;
					end else begin
						state_d = bti_pkg::S_CHK0;
					end
				end
			end
			bti_pkg::S_CHK0: begin
				rd_addr = last_q;
				state_d = bti_pkg::S_CHKLAST;
				if (key_q == rd_key || key_q < rd_key) begin
					state_d = bti_pkg::S_DONE;
				end
			end
			bti_pkg::S_CHKLAST: begin
				idx_d = IW'(1);
				rd_addr = IW'(1);
				state_d = (key_q > rd_key) ? bti_pkg::S_DONE : bti_pkg::S_SCAN;
			end
			bti_pkg::S_SCAN: begin
				if (mode_q == bti_pkg::MODE_EXACT) begin
					if (rd_day == kday_q || idx_q == last_q) begin
						state_d = bti_pkg::S_DONE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
					rd_addr = idx_d;
				end else if (key_q > rd_key && idx_q != last_q) begin
					idx_d = idx_q + 1'b1;
					rd_addr = idx_d;
				end else if (mode_q == bti_pkg::MODE_STAIRS && key_q == rd_key) begin
					state_d = bti_pkg::S_DONE;
				end else begin
					rd_addr = idx_q - 1'b1;
					state_d = bti_pkg::S_RDLEFT;
				end
			end
			bti_pkg::S_RDLEFT: begin
				rd_addr = idx_q - 1'b1;
				state_d = bti_pkg::S_GOTLEFT;
			end
			bti_pkg::S_GOTLEFT: begin
				state_d = bti_pkg::S_DONE;
				if (mode_q == bti_pkg::MODE_LINEAR && rd_day < span_q && kday_q > rd_day) begin
					state_d = bti_pkg::S_DIV1;
				end
			end
			bti_pkg::S_DIV1: begin
				if (!drsp.busy && !drsp.done) begin
					dreq.start = 1'b1;
				end
				if (drsp.done) begin
					state_d = bti_pkg::S_MUL;
				end
			end
			bti_pkg::S_MUL: begin
				state_d = bti_pkg::S_DIV2;
			end
			bti_pkg::S_DIV2: begin
				dreq.dividend = prod_q[QW-1:0];
				if (!drsp.busy && !drsp.done) begin
					dreq.start = 1'b1;
				end
				if (drsp.done) begin
					state_d = bti_pkg::S_DONE;
				end
			end
			bti_pkg::S_DONE: begin
				state_d = bti_pkg::S_IDLE;
			end
			default: begin
				state_d = bti_pkg::S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bti_pkg::S_IDLE;
			ovld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bti_pkg::S_DONE) begin
				ovld_q <= 1'b1;
			end else if (out_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		case (state_q)
			bti_pkg::S_IDLE: begin
				if (accept) begin
					kday_q <= key_day;
					key_q <= {key_day, key_time};
					last_q <= IW'(count_q - 1'b1);
					res_q <= '0;
					st_q <= bti_pkg::ST_OK;
					if (operation == bti_pkg::OP_QUERY && count_q == '0) begin
						st_q <= bti_pkg::ST_EMPTY;
					end else if (operation == bti_pkg::OP_QUERY &&
							mode_q == bti_pkg::MODE_UNUSED) begin
						st_q <= bti_pkg::ST_NOTFOUND;
					end
				end
			end
			bti_pkg::S_CHK0: begin
				if (key_q == rd_key) begin
					res_q <= rd_val;
				end else if (key_q < rd_key) begin
					st_q <= bti_pkg::ST_BOUNDS;
				end
			end
			bti_pkg::S_CHKLAST: begin
				if (key_q > rd_key) begin
					st_q <= bti_pkg::ST_BOUNDS;
				end
			end
			bti_pkg::S_SCAN: begin
				if (mode_q == bti_pkg::MODE_EXACT) begin
					if (rd_day == kday_q) begin
						res_q <= rd_val;
					end else if (idx_q == last_q) begin
						st_q <= bti_pkg::ST_NOTFOUND;
					end
				end else begin
					hi_q <= rd_val;
					span_q <= rd_day;
					if (key_q == rd_key) begin
						res_q <= rd_val;
					end
				end
			end
			bti_pkg::S_GOTLEFT: begin
				lo_q <= rd_val;
				res_q <= rd_val;
				span_q <= span_q - rd_day;
				dt_q <= kday_q - rd_day;
				neg_q <= $signed(hi_q) < $signed(rd_val);
				if ($signed(hi_q) < $signed(rd_val)) begin
					mag_q <= {rd_val[VW-1], rd_val} - {hi_q[VW-1], hi_q};
				end else begin
					mag_q <= {hi_q[VW-1], hi_q} - {rd_val[VW-1], rd_val};
				end
			end
			bti_pkg::S_MUL: begin
				qmul_q <= (VW+DW+1)'(drsp.quot[VW:0]) * (VW+DW+1)'(dt_q);
				prod_q <= (VW+DW+1)'(drsp.rem) * (VW+DW+1)'(dt_q);
			end
			bti_pkg::S_DIV2: begin
				if (drsp.done) begin
					res_q <= neg_q ? lo_q - VW'(qmul_q + (VW+DW+1)'(drsp.quot))
						: lo_q + VW'(qmul_q + (VW+DW+1)'(drsp.quot));
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = ovld_q;
	assign result_value = res_q;
	assign status = st_q;

	`ASSERT_IMPL(a_no_accept_busy, state_q != bti_pkg::S_IDLE, !in_ready)
	`ASSERT_NEXT(a_done_gives_word, state_q == bti_pkg::S_DONE, out_valid)
	`ASSERT_IMPL(a_div_linear, drsp.busy, state_q == bti_pkg::S_DIV1 || state_q == bti_pkg::S_DIV2)
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	localparam int MAX_CYCLES = 1500000;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0] st;
	} lookup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic [5:0] entry_index = '0;
	logic [19:0] key_day = '0;
	logic [16:0] key_time = '0;
	logic signed [31:0] entry_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] result_value;
	logic [1:0] status;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [6:0] cfg_data = '0;

	// predictor copy of table and registers
	logic [19:0] bp_day [bti_pkg::TableDepth];
	logic [16:0] bp_time [bti_pkg::TableDepth];
	logic signed [31:0] bp_value [bti_pkg::TableDepth];
	logic [1:0] mode_q;
	int count_q;
	lookup_t pending_lookups[$];
	int fail_count = 0;
	int cycle_count = 0;
	bit hold_sink = 1'b0;

	breakpoint_table_interpolator dut (.*);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [36:0] key_of(logic [19:0] d, logic [16:0] t);
		return {d, t};
	endfunction

	function automatic logic signed [31:0] lerp_value(int i, logic [19:0] kd);
		longint lo, hi, span, dt, mag, q, r, part;
		lo = bp_value[i-1];
		hi = bp_value[i];
		span = longint'(bp_day[i]) - longint'(bp_day[i-1]);
		dt = longint'(kd) - longint'(bp_day[i-1]);
		if (span <= 0 || dt <= 0) return 32'(lo);
		mag = (hi < lo) ? lo - hi : hi - lo;
		q = mag / span;
		r = mag % span;
		part = q * dt + (r * dt) / span;
		return (hi < lo) ? 32'(lo - part) : 32'(lo + part);
	endfunction

	function automatic lookup_t predict_lookup(logic op, logic [5:0] idx, logic [19:0] kd,
			logic [16:0] kt, logic signed [31:0] ev);
		lookup_t res;
		logic [36:0] k;
		int i;
		res = '{value: '0, st: bti_pkg::ST_OK};
		k = key_of(kd, kt);
		if (op == bti_pkg::OP_LOAD) begin
			bp_day[idx] = kd;
			bp_time[idx] = kt;
			bp_value[idx] = ev;
		end else if (count_q == 0) begin
			res.st = bti_pkg::ST_EMPTY;
		end else if (mode_q == bti_pkg::MODE_LINEAR || mode_q == bti_pkg::MODE_STAIRS) begin
			if (k == key_of(bp_day[0], bp_time[0])) begin
				res.value = bp_value[0];
			end else if (k < key_of(bp_day[0], bp_time[0]) ||
					k > key_of(bp_day[count_q-1], bp_time[count_q-1])) begin
				res.st = bti_pkg::ST_BOUNDS;
			end else begin
				for (i = 1; i < count_q - 1 && k > key_of(bp_day[i], bp_time[i]); i++) ;
				if (mode_q == bti_pkg::MODE_STAIRS)
					res.value = (k == key_of(bp_day[i], bp_time[i])) ? bp_value[i]
						: bp_value[i-1];
				else
					res.value = lerp_value(i, kd);
			end
		end else if (mode_q == bti_pkg::MODE_EXACT) begin
			res.st = bti_pkg::ST_NOTFOUND;
			for (i = 0; i < count_q; i++) begin
				if (bp_day[i] == kd) begin
					res.value = bp_value[i];
					res.st = bti_pkg::ST_OK;
					break;
				end
			end
		end else begin
			res.st = bti_pkg::ST_NOTFOUND;
		end
		return res;
	endfunction

	// send one word and queue its expected lookup
	task automatic send_word(logic op, logic [5:0] idx, logic [19:0] kd, logic [16:0] kt,
			logic signed [31:0] ev);
		@(negedge clk);
		repeat (gap_len()) @(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		key_day <= kd;
		key_time <= kt;
		entry_value <= ev;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_lookups.insert(pending_lookups.size(), predict_lookup(op, idx, kd, kt, ev));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_lookups.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// register write, only while idle
	task automatic write_reg(logic idx, logic [6:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == bti_pkg::CFG_MODE) mode_q = data[1:0];
		else count_q = (int'(data) > bti_pkg::TableDepth) ? bti_pkg::TableDepth : int'(data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result checker with random backpressure
	always @(posedge clk) begin
		lookup_t exp_l;
		if (out_valid && out_ready) begin
			if (pending_lookups.size() == 0) begin
				$error("unexpected word value=%0d status=%0d", result_value, status);
				fail_count++;
			end else begin
				exp_l = pending_lookups.pop_front();
				if (result_value !== exp_l.value) begin
					$error("result_value expected %0d actual %0d", exp_l.value, result_value);
					fail_count++;
				end
				if (status !== exp_l.st) begin
					$error("status expected %0d actual %0d", exp_l.st, status);
					fail_count++;
				end
			end
		end
	end

	always begin
		int gap_n;
		@(negedge clk);
		gap_n = gap_len();
		if (gap_n != 0) begin
			out_ready <= 1'b0;
			repeat (gap_n) @(negedge clk);
		end
		out_ready <= 1'b1;
		@(negedge clk);
		while (hold_sink) @(negedge clk);
		repeat ($urandom_range(0, 20)) @(negedge clk);
	end

	// load a table of n entries in key order (unless day or time wraps), random days and values
	task automatic load_sorted(int n, int max_step);
		logic [19:0] d;
		logic [16:0] t;
		int j;
		d = 20'($urandom_range(0, 1000));
		t = 17'($urandom_range(0, 86399));
		for (j = 0; j < n; j++) begin
			send_word(bti_pkg::OP_LOAD, 6'(j), d, t, $urandom());
			if ($urandom_range(0, 3) == 0) t = 17'(t + $urandom_range(1, 5000));
			else d = 20'(d + $urandom_range(0, max_step));
		end
	endtask

	function automatic logic [19:0] near_day();
		int j;
		j = $urandom_range(0, count_q - 1);
		return 20'(bp_day[j] + $urandom_range(0, 4) - 2);
	endfunction

	task automatic test_directed();
		int j;
		// empty table in linear and exact mode
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd5, 17'd0, 32'sd0);
		write_reg(bti_pkg::CFG_MODE, 7'(bti_pkg::MODE_EXACT));
		send_word(bti_pkg::OP_QUERY, 6'd63, 20'hFFFFF, 17'h1FFFF, 32'sd0);
		// extreme loads
		send_word(bti_pkg::OP_LOAD, 6'd0, 20'd0, 17'd0, 32'sh80000000);
		send_word(bti_pkg::OP_LOAD, 6'd1, 20'd1000, 17'd100, 32'sh7FFFFFFF);
		send_word(bti_pkg::OP_LOAD, 6'd2, 20'hFFFFF, 17'h1FFFF, -32'sd1);
		send_word(bti_pkg::OP_LOAD, 6'd63, 20'hFFFFF, 17'h1FFFF, 32'sd0);
		write_reg(bti_pkg::CFG_COUNT, 7'd3);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd1000, 17'd0, 32'sd0);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd7, 17'd0, 32'sd0);
		write_reg(bti_pkg::CFG_MODE, 7'(bti_pkg::MODE_LINEAR));
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd0, 17'd0, 32'sd0);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd500, 17'd5, 32'sd0);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd2000, 17'd5, 32'sd0);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'hFFFFF, 17'h1FFFF, 32'sd0);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'hFFFFF, 17'h1FFFE, 32'sd0);
		write_reg(bti_pkg::CFG_MODE, 7'(bti_pkg::MODE_STAIRS));
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd1000, 17'd100, 32'sd0);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd999, 17'd0, 32'sd0);
		write_reg(bti_pkg::CFG_MODE, 7'(bti_pkg::MODE_UNUSED));
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd1000, 17'd100, 32'sd0);
		// fill every slot, then oversized count saturates
		for (j = 0; j < bti_pkg::TableDepth; j++)
			send_word(bti_pkg::OP_LOAD, 6'(j), 20'(j * 10), 17'd0, 32'(j * 65536));
		write_reg(bti_pkg::CFG_COUNT, 7'd127);
		write_reg(bti_pkg::CFG_MODE, 7'(bti_pkg::MODE_LINEAR));
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd630, 17'd0, 32'sd0);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd631, 17'd0, 32'sd0);
		write_reg(bti_pkg::CFG_COUNT, 7'd64);
		send_word(bti_pkg::OP_QUERY, 6'd0, 20'd315, 17'd1, 32'sd0);
	endtask

	task automatic test_random_phases();
		int ph, j, n;
		logic [19:0] kd;
		for (ph = 0; ph < 16; ph++) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 8);
			write_reg(bti_pkg::CFG_COUNT, 7'd0);
			load_sorted(n, (ph % 3 == 0) ? 3 : 100000);
			write_reg(bti_pkg::CFG_COUNT, 7'(n));
			write_reg(bti_pkg::CFG_MODE, 7'($urandom_range(0, 3)));
			for (j = 0; j < 20; j++) begin
				kd = ($urandom_range(0, 9) == 0) ? 20'($urandom()) : near_day();
				if ($urandom_range(0, 9) == 0)
					send_word(bti_pkg::OP_LOAD, 6'($urandom_range(0, n - 1)),
						20'($urandom()), 17'($urandom()), $urandom());
				else
					send_word(bti_pkg::OP_QUERY, 6'($urandom()), kd,
						($urandom_range(0, 3) == 0) ? 17'($urandom())
						: bp_time[$urandom_range(0, n - 1)], $urandom());
			end
			if (ph == 5) begin
				// wait out all results before sending more
				while (pending_lookups.size() != 0) @(negedge clk);
			end
			if (ph == 10) hold_sink = 1'b1;
			if (ph == 12) hold_sink = 1'b0;
		end
	endtask

	initial begin
		mode_q = bti_pkg::MODE_LINEAR;
		count_q = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random_phases();
		drain();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
